// ===== hdl/ip6cs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ip6cs_pkg
// Shared types, register indexes and ones-complement helpers for the IPv6
// pseudo-header checksum block.
// ---------------------------------------------------------------------------
package ip6cs_pkg;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned CSR_W  = 64;
   localparam int unsigned ADDR_W = 3;

   localparam logic [7:0]        UDP_PROTOCOL = 8'd17;
   localparam logic [WORD_W-1:0] ALL_ONES     = 16'hFFFF;

   typedef enum logic [ADDR_W-1:0] {
      CSR_SRC_HI  = 3'd0,
      CSR_SRC_LO  = 3'd1,
      CSR_DST_HI  = 3'd2,
      CSR_DST_LO  = 3'd3,
      CSR_NXT_HDR = 3'd4,
      CSR_PAY_LEN = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
      logic              last;
   } beat_type;

   // 16-bit add with end-around carry
   function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
   endfunction

   function automatic logic [WORD_W-1:0] fold64(input logic [63:0] v);
      return oc_add(oc_add(v[63:48], v[47:32]), oc_add(v[31:16], v[15:0]));
   endfunction

endpackage : ip6cs_pkg
`default_nettype wire

// ===== hdl/ip6cs_csr.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ip6cs_csr
// Configuration registers. Address and length writes fold to 16-bit partial
// sums; the pseudo-header sum is rebuilt from the partials every cycle.
// ---------------------------------------------------------------------------
module ip6cs_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [ip6cs_pkg::ADDR_W-1:0] csr_index,
   input  wire logic [ip6cs_pkg::CSR_W-1:0]  csr_wdata,
   output logic      [ip6cs_pkg::WORD_W-1:0] ph_sum,
   output logic      [7:0]                   next_header
);

   logic [ip6cs_pkg::WORD_W-1:0] part_ff [5];
   logic [7:0]                   nh_ff;
   logic [ip6cs_pkg::WORD_W-1:0] ph_sum_ff;
   logic [ip6cs_pkg::WORD_W-1:0] ph_sum_in;
   logic [ip6cs_pkg::WORD_W-1:0] wfold;
   logic [ip6cs_pkg::WORD_W-1:0] lfold;

   assign wfold = ip6cs_pkg::fold64(csr_wdata);
   assign lfold = ip6cs_pkg::oc_add(csr_wdata[31:16], csr_wdata[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) part_ff[i] <= '0;
         nh_ff <= ip6cs_pkg::UDP_PROTOCOL;
      end else if (csr_wr_en) begin
         case (ip6cs_pkg::csr_index_type'(csr_index))
            ip6cs_pkg::CSR_SRC_HI:  part_ff[0] <= wfold;
            ip6cs_pkg::CSR_SRC_LO:  part_ff[1] <= wfold;
            ip6cs_pkg::CSR_DST_HI:  part_ff[2] <= wfold;
            ip6cs_pkg::CSR_DST_LO:  part_ff[3] <= wfold;
            ip6cs_pkg::CSR_NXT_HDR: nh_ff      <= csr_wdata[7:0];
            ip6cs_pkg::CSR_PAY_LEN: part_ff[4] <= lfold;
            default: ;
         endcase
      end
   end

   assign ph_sum_in = ip6cs_pkg::oc_add(
      ip6cs_pkg::oc_add(ip6cs_pkg::oc_add(part_ff[0], part_ff[1]),
                        ip6cs_pkg::oc_add(part_ff[2], part_ff[3])),
      ip6cs_pkg::oc_add(part_ff[4], {8'h00, nh_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_sum_ff <= {8'h00, ip6cs_pkg::UDP_PROTOCOL};
      end else begin
         ph_sum_ff <= ph_sum_in;
      end
   end

   assign ph_sum      = ph_sum_ff;
   assign next_header = nh_ff;

endmodule : ip6cs_csr
`default_nettype wire

// ===== hdl/ip6cs_ingress.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ip6cs_ingress
// Input register. Masks the pad byte of an odd final beat.
// ---------------------------------------------------------------------------
module ip6cs_ingress (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [ip6cs_pkg::WORD_W-1:0] req_tdata,
   input  wire logic                         req_tlast,
   input  wire logic                         req_tuser,
   input  wire logic                         take,
   output ip6cs_pkg::beat_type               beat
);

   ip6cs_pkg::beat_type beat_ff;
   ip6cs_pkg::beat_type beat_in;
   logic                accept;

   assign req_tready = !beat_ff.valid || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      beat_in = beat_ff;
      if (accept) begin
         beat_in.valid = 1'b1;
         beat_in.last  = req_tlast;
         beat_in.word  = req_tdata;
         if (req_tlast && req_tuser) beat_in.word[7:0] = 8'h00;
      end else if (take) begin
         beat_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.word <= beat_in.word;
      beat_ff.last <= beat_in.last;
   end

   assign beat = beat_ff;

endmodule : ip6cs_ingress
`default_nettype wire

// ===== hdl/ip6cs_sum.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ip6cs_sum
// Running ones-complement sum and result register.
// ---------------------------------------------------------------------------
module ip6cs_sum (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ip6cs_pkg::beat_type          beat,
   input  wire logic [ip6cs_pkg::WORD_W-1:0] ph_sum,
   input  wire logic [7:0]                   next_header,
   output logic                              take,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [ip6cs_pkg::WORD_W-1:0] rsp_tdata
);

   logic [ip6cs_pkg::WORD_W-1:0] run_ff;
   logic [ip6cs_pkg::WORD_W-1:0] run_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [ip6cs_pkg::WORD_W-1:0] rsp_data_ff;
   logic [ip6cs_pkg::WORD_W-1:0] rsp_data_in;
   logic [ip6cs_pkg::WORD_W-1:0] acc;
   logic [ip6cs_pkg::WORD_W-1:0] csum;

   assign take = beat.valid && (!beat.last || !rsp_valid_ff || rsp_tready);
   assign acc  = ip6cs_pkg::oc_add(run_ff, beat.word);
   assign csum = ~ip6cs_pkg::oc_add(acc, ph_sum);

   always_comb begin
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         if (beat.last) begin
            run_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = csum;
            if (next_header == ip6cs_pkg::UDP_PROTOCOL && csum == '0)
               rsp_data_in = ip6cs_pkg::ALL_ONES;
         end else begin
            run_in = acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : ip6cs_sum
`default_nettype wire

// ===== hdl/ipv6_pseudo_header_checksum_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ipv6_pseudo_header_checksum_top
// Internet checksum of a payload plus the IPv6 pseudo-header.
// ---------------------------------------------------------------------------
// Takes one 16-bit payload beat per clock unless a final beat is held behind
// a waiting checksum. Each beat passes an input register and then the
// running-sum adder; a final beat's checksum lands in the result register.
// The input register also serves as the skid stage: new beats keep flowing
// while a checksum waits on rsp_tready, and only a second final beat stalls
// behind it. The pseudo-header sum is folded from the csr registers and
// applies to items accepted from the cycle after the write.
module ipv6_pseudo_header_checksum_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] payload_word
   input  wire logic        req_tlast,   // final_word
   input  wire logic        req_tuser,   // [0] single_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [15:0] checksum
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   ip6cs_pkg::beat_type          beat;
   logic                         take;
   logic [ip6cs_pkg::WORD_W-1:0] ph_sum;
   logic [7:0]                   next_header;

   ip6cs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ph_sum      (ph_sum),
      .next_header (next_header)
   );

   ip6cs_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .take       (take),
      .beat       (beat)
   );

   ip6cs_sum u_sum (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .ph_sum      (ph_sum),
      .next_header (next_header),
      .take        (take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // final beat moved into the sum stage yields a checksum next cycle
   a_final_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (beat.valid && beat.last && take) |=> rsp_tvalid)
      else $error("final beat produced no checksum");

   // a held beat stays put in the input register
   a_beat_held: assert property (@(posedge clock) disable iff (reset)
      (beat.valid && !take) |=> (beat.valid && $stable(beat.word) && $stable(beat.last)))
      else $error("stalled beat changed");

   // UDP never reports a zero checksum
   a_udp_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && $past(next_header) == ip6cs_pkg::UDP_PROTOCOL &&
       next_header == ip6cs_pkg::UDP_PROTOCOL && $rose(rsp_tvalid)) |-> (rsp_tdata != '0))
      else $error("zero checksum under UDP");

   // a waiting checksum blocks a second final beat
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && beat.valid && beat.last) |-> !take)
      else $error("checksum overwritten");

endmodule : ipv6_pseudo_header_checksum_top
`default_nettype wire

// ===== test/ipv6_pseudo_header_checksum_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ipv6_pseudo_header_checksum_checker
// Watches the payload, checksum and csr ports of the IPv6 pseudo-header
// checksum block, keeps its own copy of the register file and the running
// ones-complement sum, and compares every checksum beat in order against
// the value computed when the final payload beat went in.
// ---------------------------------------------------------------------------
module ipv6_pseudo_header_checksum_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output int               fail_count,
   output int               pending
);

   logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
   logic [7:0]  nxt_hdr;
   logic [31:0] pay_len;
   logic [15:0] payload_sum;
   logic [15:0] checksum_queue[$];

   function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > 17'h0FFFF) s = s - 17'h0FFFF;
      return s[15:0];
   endfunction

   function automatic logic [15:0] quad_sum(input logic [15:0] acc, input logic [63:0] v);
      acc = ones_sum(acc, v[63:48]);
      acc = ones_sum(acc, v[47:32]);
      acc = ones_sum(acc, v[31:16]);
      return ones_sum(acc, v[15:0]);
   endfunction

   function automatic logic [15:0] header_sum();
      logic [15:0] acc;
      acc = quad_sum(16'h0000, src_hi);
      acc = quad_sum(acc, src_lo);
      acc = quad_sum(acc, dst_hi);
      acc = quad_sum(acc, dst_lo);
      acc = ones_sum(acc, pay_len[31:16]);
      acc = ones_sum(acc, pay_len[15:0]);
      return ones_sum(acc, {8'h00, nxt_hdr});
   endfunction

   function automatic logic [15:0] final_checksum(input logic [15:0] total);
      logic [15:0] r;
      r = ~total;
      // UDP sends an all-zero checksum as all ones
      if (nxt_hdr == ip6cs_pkg::UDP_PROTOCOL && r == 16'h0000) r = ip6cs_pkg::ALL_ONES;
      return r;
   endfunction

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      $display("%0t: checksum %s: got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : monitor
      logic [15:0] word;
      logic [15:0] want;
      if (reset) begin
         src_hi      = '0;
         src_lo      = '0;
         dst_hi      = '0;
         dst_lo      = '0;
         nxt_hdr     = ip6cs_pkg::UDP_PROTOCOL;
         pay_len     = '0;
         payload_sum = '0;
         checksum_queue.delete();
         fail_count  = 0;
         pending    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            word = req_tdata;
            if (req_tlast && req_tuser) word[7:0] = 8'h00;
            payload_sum = ones_sum(payload_sum, word);
            if (req_tlast) begin
               checksum_queue.push_back(final_checksum(ones_sum(payload_sum, header_sum())));
               payload_sum = '0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (checksum_queue.size() == 0) begin
               report("beat with nothing outstanding", rsp_tdata, 16'h0000);
            end else begin
               want = checksum_queue.pop_front();
               if (rsp_tdata !== want) report("mismatch", rsp_tdata, want);
            end
         end
         // register writes apply to beats from the next cycle on
         if (csr_wr_en) begin
            case (csr_index)
               ip6cs_pkg::CSR_SRC_HI:  src_hi  = csr_wdata;
               ip6cs_pkg::CSR_SRC_LO:  src_lo  = csr_wdata;
               ip6cs_pkg::CSR_DST_HI:  dst_hi  = csr_wdata;
               ip6cs_pkg::CSR_DST_LO:  dst_lo  = csr_wdata;
               ip6cs_pkg::CSR_NXT_HDR: nxt_hdr = csr_wdata[7:0];
               ip6cs_pkg::CSR_PAY_LEN: pay_len = csr_wdata[31:0];
               default: ;
            endcase
         end
         pending <= checksum_queue.size();
      end
   end

endmodule : ipv6_pseudo_header_checksum_checker
`default_nettype wire

// ===== test/ipv6_pseudo_header_checksum_top_tb.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ipv6_pseudo_header_checksum_top_tb
// Regression for the IPv6 pseudo-header checksum block.
// ---------------------------------------------------------------------------
// A directed run covers carries, the UDP all-ones rule, odd final bytes and
// extreme register values; random phases then reprogram the registers and
// stream packets of random length with random gaps and checksum stalls.
// The checker instance does all prediction and comparison.
module ipv6_pseudo_header_checksum_top_tb;

   localparam int          ITEM_TARGET  = 1050;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          TAIL_CYCLES  = 8;
   localparam logic [7:0]  TCP_PROTOCOL = 8'd6;
   localparam logic [2:0]  CSR_SPARE_A  = 3'd6;
   localparam logic [2:0]  CSR_SPARE_B  = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] payload_word
   logic        req_tlast;   // final_word
   logic        req_tuser;   // [0] single_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] checksum
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   int failures;
   int pending;
   int sent   = 0;
   int cycles = 0;
   bit calm   = 1'b0;

   ipv6_pseudo_header_checksum_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ipv6_pseudo_header_checksum_checker checksum_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [63:0] pick_quad();
      case ($urandom_range(5))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] pick_next_header();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(6))
         0, 1, 2: v[7:0] = ip6cs_pkg::UDP_PROTOCOL;
         3:       v[7:0] = 8'h00;
         4:       v[7:0] = 8'hFF;
         5:       v[7:0] = TCP_PROTOCOL;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] pick_length();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(3))
         0: v[31:0] = 32'h0;
         1: v[31:0] = '1;
         2: v[31:0] = $urandom_range(1, 1500);
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // rsp_tready pacing runs for the whole simulation
   initial begin : rsp_pacing
      int run;
      int gap;
      forever begin
         rsp_tready <= 1'b1;
         run = $urandom_range(1, 40);
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic send(input logic [15:0] word, input bit last, input bit single);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= last;
      req_tuser  <= single;
      do @(posedge clock); while (!req_tready);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic put_csr(input logic [2:0] idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [63:0] s_hi, input logic [63:0] s_lo,
                             input logic [63:0] d_hi, input logic [63:0] d_lo,
                             input logic [63:0] nh, input logic [63:0] len,
                             input bit spare);
      put_csr(ip6cs_pkg::CSR_SRC_HI, s_hi);
      put_csr(ip6cs_pkg::CSR_SRC_LO, s_lo);
      put_csr(ip6cs_pkg::CSR_DST_HI, d_hi);
      put_csr(ip6cs_pkg::CSR_DST_LO, d_lo);
      put_csr(ip6cs_pkg::CSR_NXT_HDR, nh);
      put_csr(ip6cs_pkg::CSR_PAY_LEN, len);
      // writes to unused indexes must leave the registers alone
      if (spare) begin
         put_csr(CSR_SPARE_A, {$urandom, $urandom});
         put_csr(CSR_SPARE_B, {$urandom, $urandom});
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int packets;
      int words;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_tuser  = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = ip6cs_pkg::CSR_SRC_HI;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset registers: header sum is the UDP protocol number alone
      send(16'hFFEE, 1'b1, 1'b0);
      send(16'h0000, 1'b1, 1'b0);
      send(16'hFFFF, 1'b0, 1'b0);
      send(16'hFFFF, 1'b0, 1'b1);
      send(16'hABCD, 1'b1, 1'b1);
      send(16'h8000, 1'b0, 1'b0);
      send(16'h8000, 1'b1, 1'b0);
      settle();

      set_config('1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF, '1, 1'b1);
      send(16'h0000, 1'b1, 1'b0);
      send(16'hFFFF, 1'b1, 1'b1);
      send(16'h1234, 1'b0, 1'b1);
      send(16'h00FF, 1'b1, 1'b1);
      settle();

      // non-UDP zero checksum stays zero
      set_config('0, '0, '0, '0, {56'h0, TCP_PROTOCOL}, '0, 1'b0);
      send(16'hFFF9, 1'b1, 1'b0);
      send(16'h0000, 1'b1, 1'b0);
      settle();

      // length field disagrees with the words sent
      set_config('0, '0, '0, '0, 64'h0, 64'h0001_0002, 1'b0);
      send(16'h5A5A, 1'b0, 1'b0);
      send(16'hA5A5, 1'b0, 1'b0);
      send(16'h0001, 1'b1, 1'b0);
      settle();

      while (sent < ITEM_TARGET) begin
         calm = ($urandom_range(3) == 0);
         set_config(pick_quad(), pick_quad(), pick_quad(), pick_quad(),
                    pick_next_header(), pick_length(), $urandom_range(3) == 0);
         packets = $urandom_range(4, 16);
         repeat (packets) begin
            words = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            for (int i = 1; i <= words; i++)
               send(pick_word(), i == words, $urandom_range(3) == 0);
         end
         settle();
      end

      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule : ipv6_pseudo_header_checksum_top_tb
`default_nettype wire
